FILE: sv/button_gesture_led_breath_control_top_macros.svh
// Assertion macros shared by the event queue and LED machine RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BUTTON_GESTURE_LED_BREATH_CONTROL_TOP_MACROS_SVH
`define BUTTON_GESTURE_LED_BREATH_CONTROL_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define BGLB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bglb assertion failed");

// Next-cycle implication, off while reset is held.
`define BGLB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bglb assertion failed");

`endif

FILE: sv/bglb_pkg.sv
// ----------------------------------------------------------------------------
// bglb_pkg
// Shared types and constants for the button gesture and LED breathing block.
// ----------------------------------------------------------------------------
`default_nettype none

package bglb_pkg;

    localparam int COUNT_BITS = 16;
    localparam int DUTY_BITS  = 8;
    localparam int DUTY_STEP  = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Key events.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_LONG     = 2'd1;
    localparam logic [1:0] EV_LONG_REL = 2'd2;
    localparam logic [1:0] EV_DOUBLE   = 2'd3;

    // LED modes.
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_HOLD    = 3'd1;
    localparam logic [2:0] MODE_BOTH_ON = 3'd2;
    localparam logic [2:0] MODE_RAMP    = 3'd3;
    localparam logic [2:0] MODE_FROZEN  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_DOUBLE_GAP  = 2'd1;
    localparam logic [1:0] REG_BREATH_STEP = 2'd2;
    localparam logic [1:0] REG_DUTY_MAX    = 2'd3;

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [15:0] double_gap_ticks;
        logic [15:0] breath_step_ticks;
        logic [7:0]  duty_max;
    } cfg_t;

    // One event word handed from the detector to the queue.
    typedef struct packed {
        logic       valid;
        logic [1:0] ev;
    } ev_push_t;

    // Queue status seen by the LED machine.
    typedef struct packed {
        logic       valid;
        logic [1:0] ev;
    } ev_head_t;

endpackage

`default_nettype wire

FILE: sv/button_gesture_led_breath_control_top.sv
// ----------------------------------------------------------------------------
// button_gesture_led_breath_control_top
// Button long-press / double-click detector driving a five-mode LED machine.
//
//   channel  signals                                           direction
//   input    in_valid, in_ready, key_pressed                   in
//   output   out_valid, out_ready, pwm_duty, led1_switch,
//            led2_on, led_mode, key_event                      out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data         in
//
// One scan tick is taken per clock while the queue is not full; each word's
// result is registered in the queue, then in the LED machine's output reg.
// The two-entry event queue lets the detector keep accepting while a result
// waits; the input stalls only when the queue is full.
// Reset is asynchronous; it restores config and control state, not data regs.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_led_breath_control_top
    import bglb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        key_pressed,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       pwm_duty,
    output logic             led1_switch,
    output logic             led2_on,
    output logic [2:0]       led_mode,
    output logic [1:0]       key_event,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t     cfg_reg;
    ev_push_t push;
    ev_head_t head;
    logic     q_full;
    logic     pop;
    logic     accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks  <= 16'd200;
            cfg_reg.double_gap_ticks  <= 16'd60;
            cfg_reg.breath_step_ticks <= 16'd4;
            cfg_reg.duty_max          <= 8'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_PRESS:  cfg_reg.long_press_ticks  <= cfg_data;
                REG_DOUBLE_GAP:  cfg_reg.double_gap_ticks  <= cfg_data;
                REG_BREATH_STEP: cfg_reg.breath_step_ticks <= cfg_data;
                REG_DUTY_MAX:    cfg_reg.duty_max          <= cfg_data[7:0];
                default:         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    bglb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .key_pressed (key_pressed),
        .cfg         (cfg_reg),
        .push        (push)
    );

    bglb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    bglb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .cfg         (cfg_reg),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pwm_duty    (pwm_duty),
        .led1_switch (led1_switch),
        .led2_on     (led2_on),
        .led_mode    (led_mode),
        .key_event   (key_event)
    );

endmodule

`default_nettype wire

FILE: sv/bglb_front.sv
// ----------------------------------------------------------------------------
// bglb_front
// Gesture detector: tracks the key level and tick counters, emits one event
// word for every accepted scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bglb_front
    import bglb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire logic     key_pressed,
    input  wire cfg_t     cfg,
    output ev_push_t      push
);

    logic                  level_reg, level_next;
    logic [COUNT_BITS-1:0] press_cnt_reg, press_cnt_next;
    logic [COUNT_BITS-1:0] rel_cnt_reg, rel_cnt_next;
    logic                  long_reg, long_next;
    logic                  short_reg, short_next;
    logic [1:0]            ev;
    logic [COUNT_BITS-1:0] press_inc;
    logic [COUNT_BITS-1:0] rel_inc;
    logic                  in_gap;
    logic                  long_due;

    assign press_inc = (press_cnt_reg == CNT_MAX) ? CNT_MAX : press_cnt_reg + 1'b1;
    assign rel_inc   = (rel_cnt_reg == CNT_MAX) ? CNT_MAX : rel_cnt_reg + 1'b1;
    assign in_gap    = ({16'd0, rel_inc} < {{COUNT_BITS{1'b0}}, cfg.double_gap_ticks});
    assign long_due  = ({16'd0, press_inc} >= {{COUNT_BITS{1'b0}}, cfg.long_press_ticks});

    always_comb
    begin
        level_next     = level_reg;
        press_cnt_next = press_inc;
        rel_cnt_next   = rel_inc;
        long_next      = long_reg;
        short_next     = short_reg;
        ev             = EV_NONE;
        if (key_pressed != level_reg)
        begin
            level_next = key_pressed;
            if (key_pressed)
            begin
                press_cnt_next = '0;
                long_next      = 1'b0;
                if (short_reg && in_gap)
                begin
                    short_next = 1'b0;
                    ev         = EV_DOUBLE;
                end
            end
            else
            begin
                rel_cnt_next = '0;
                if (long_reg)
                begin
                    ev = EV_LONG_REL;
                end
                else
                begin
                    short_next = 1'b1;
                end
            end
        end
        else
        begin
            if (key_pressed && !long_reg && long_due)
            begin
                long_next = 1'b1;
                ev        = EV_LONG;
            end
            if (short_reg && !in_gap)
            begin
                short_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= 1'b0;
            press_cnt_reg <= '0;
            rel_cnt_reg   <= '0;
            long_reg      <= 1'b0;
            short_reg     <= 1'b0;
        end
        else if (accept)
        begin
            level_reg     <= level_next;
            press_cnt_reg <= press_cnt_next;
            rel_cnt_reg   <= rel_cnt_next;
            long_reg      <= long_next;
            short_reg     <= short_next;
        end
    end

    assign push.valid = accept;
    assign push.ev    = ev;

endmodule

`default_nettype wire

FILE: sv/bglb_queue.sv
// ----------------------------------------------------------------------------
// bglb_queue
// Short event queue between the gesture detector and the LED machine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_led_breath_control_top_macros.svh"

module bglb_queue
    import bglb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ev_push_t push,
    input  wire logic     pop,
    output logic          full,
    output ev_head_t      head
);

    logic [1:0]      ent_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == Q_CW'(Q_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.ev    = ent_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            ent_reg[wr_ptr_reg] <= push.ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    `BGLB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= Q_CW'(Q_DEPTH))
    `BGLB_ASSERT_IMP(a_pop_nonempty, pop, cnt_reg != '0)
    `BGLB_ASSERT_NXT(a_push_grows, push.valid && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

`default_nettype wire

FILE: sv/bglb_back.sv
// ----------------------------------------------------------------------------
// bglb_back
// LED mode machine: applies one event word per cycle unless out_ready stalls
// it, runs the breathing ramp and holds the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_led_breath_control_top_macros.svh"

module bglb_back
    import bglb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ev_head_t head,
    input  wire cfg_t     cfg,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [7:0]    pwm_duty,
    output logic          led1_switch,
    output logic          led2_on,
    output logic [2:0]    led_mode,
    output logic [1:0]    key_event
);

    logic [2:0]           mode_reg, mode_next;
    logic [DUTY_BITS-1:0] duty_reg, duty_next;
    logic                 down_reg, down_next;
    logic [15:0]          step_reg, step_next;
    logic [DUTY_BITS-1:0] frozen_reg, frozen_next;
    logic                 latch_reg, latch_next;
    logic                 out_valid_reg;
    logic [7:0]           pwm_reg, pwm_next;
    logic                 led2_reg, led2_next;
    logic [1:0]           event_reg;
    logic [15:0]          step_inc;
    logic [DUTY_BITS:0]   ramp_sum;
    logic [DUTY_BITS:0]   ramp_val;
    logic [DUTY_BITS-1:0] duty_ev;
    logic                 down_ev;

    assign pop = head.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        mode_next   = mode_reg;
        duty_ev     = duty_reg;
        down_ev     = down_reg;
        frozen_next = frozen_reg;
        case (head.ev)
            EV_LONG:     mode_next = MODE_HOLD;
            EV_LONG_REL: mode_next = MODE_BOTH_ON;
            EV_DOUBLE:
            begin
                if (mode_reg != MODE_RAMP)
                begin
                    mode_next = MODE_RAMP;
                    duty_ev   = '0;
                    down_ev   = 1'b0;
                end
                else
                begin
                    frozen_next = duty_reg;
                    mode_next   = MODE_FROZEN;
                end
            end
            default:     mode_next = mode_reg;
        endcase
    end

    // Breathing ramp: one step of DUTY_STEP each time the step counter expires.
    assign step_inc = step_reg + 1'b1;
    assign ramp_sum = {1'b0, duty_ev} + (DUTY_BITS+1)'(DUTY_STEP);
    assign ramp_val = {1'b0, duty_ev} - (DUTY_BITS+1)'(DUTY_STEP);

    always_comb
    begin
        duty_next = duty_ev;
        down_next = down_ev;
        step_next = step_reg;
        if (mode_next == MODE_RAMP)
        begin
            step_next = step_inc;
            if (step_inc >= cfg.breath_step_ticks)
            begin
                step_next = '0;
                if (down_ev && (duty_ev <= DUTY_BITS'(DUTY_STEP)))
                begin
                    duty_next = '0;
                    down_next = 1'b0;
                end
                else if ((down_ev ? ramp_val : ramp_sum) >= {1'b0, cfg.duty_max})
                begin
                    duty_next = cfg.duty_max;
                    down_next = 1'b1;
                end
                else
                begin
                    duty_next = down_ev ? ramp_val[DUTY_BITS-1:0] : ramp_sum[DUTY_BITS-1:0];
                end
            end
        end
    end

    always_comb
    begin
        latch_next = latch_reg;
        led2_next  = 1'b0;
        pwm_next   = '0;
        case (mode_next)
            MODE_OFF:    latch_next = 1'b0;
            MODE_HOLD:
            begin
                latch_next = 1'b1;
                pwm_next   = cfg.duty_max;
            end
            MODE_BOTH_ON:
            begin
                latch_next = 1'b1;
                led2_next  = 1'b1;
                pwm_next   = cfg.duty_max;
            end
            MODE_RAMP:   pwm_next = duty_next;
            MODE_FROZEN: pwm_next = frozen_next;
            default:     pwm_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            duty_reg      <= '0;
            down_reg      <= 1'b0;
            step_reg      <= '0;
            frozen_reg    <= '0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg      <= mode_next;
                duty_reg      <= duty_next;
                down_reg      <= down_next;
                step_reg      <= step_next;
                frozen_reg    <= frozen_next;
                latch_reg     <= latch_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pwm_reg   <= pwm_next;
            led2_reg  <= led2_next;
            event_reg <= head.ev;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_duty    = pwm_reg;
    assign led1_switch = latch_reg;
    assign led2_on     = led2_reg;
    assign led_mode    = mode_reg;
    assign key_event   = event_reg;

    `BGLB_ASSERT_IMP(a_led2_all_on, out_valid_reg && led2_reg, mode_reg == MODE_BOTH_ON)
    `BGLB_ASSERT_NXT(a_double_freezes, pop && head.ev == EV_DOUBLE && mode_reg == MODE_RAMP,
                     mode_reg == MODE_FROZEN)
    `BGLB_ASSERT_NXT(a_pop_fills_out, pop, out_valid_reg)

endmodule

`default_nettype wire
